// File: rtl/ssc_pkg.sv
// Shared types, constants and helper functions for the two-square pair counter.
package ssc_pkg;

    localparam int INPUT_W = 32;
    localparam int COUNT_W = 16;
    localparam int EXP_W   = 6;
    // The divisor product saturates at this width; the final count saturates anyway.
    localparam int PROD_W  = 18;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [PROD_W-1:0]  PROD_MAX  = {PROD_W{1'b1}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_WAIT,
        ST_TAIL,
        ST_FINISH
    } ssc_state_t;

    // Multiply the running product by (exponent + 1), clamping at all ones.
    function automatic logic [PROD_W-1:0] sat_mul(input logic [PROD_W-1:0] prod,
                                                  input logic [EXP_W:0]    factor);
        logic [PROD_W+EXP_W:0] full;
        full = {{(EXP_W+1){1'b0}}, prod} * {{PROD_W{1'b0}}, factor};
        if (full[PROD_W+EXP_W:PROD_W] != '0)
            sat_mul = PROD_MAX;
        else
            sat_mul = full[PROD_W-1:0];
    endfunction

    // Turn r2 = 4 * prod into the count of unordered positive pairs.
    function automatic logic [COUNT_W-1:0] pair_calc(input logic [PROD_W-1:0] prod,
                                                     input logic forb,
                                                     input logic axis,
                                                     input logic diag);
        logic [PROD_W+2:0] total;
        logic [PROD_W+2:0] axis_w;
        logic [PROD_W-1:0] cnt;
        total  = forb ? '0 : {1'b0, prod, 2'b00};
        total  = total + (diag ? (PROD_W+3)'(4) : '0);
        axis_w = axis ? (PROD_W+3)'(4) : '0;
        if (total < axis_w)
            cnt = '0;
        else
            cnt = PROD_W'((total - axis_w) >> 3);
        if (cnt > PROD_W'(COUNT_MAX))
            pair_calc = COUNT_MAX;
        else
            pair_calc = cnt[COUNT_W-1:0];
    endfunction

endpackage

// File: rtl/ssc_div.sv
// Restoring divider, one quotient bit per cycle, shared by every trial division.
module ssc_div #(
    parameter int WIDTH     = 32,
    parameter int DIV_WIDTH = 18
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [WIDTH-1:0]     dividend,
    input  logic [DIV_WIDTH-1:0] divisor,
    output logic                 done,
    output logic [WIDTH-1:0]     quotient,
    output logic [DIV_WIDTH-1:0] remainder
);

    localparam int CW = $clog2(WIDTH + 1);
    localparam logic [CW-1:0] CNT_INIT = CW'(WIDTH);

    logic [DIV_WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0]     quo_reg, quo_next;
    logic [DIV_WIDTH-1:0] dsr_reg, dsr_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_WIDTH:0]   trial;
    logic [DIV_WIDTH:0]   diff;

    assign trial = {rem_reg, quo_reg[WIDTH-1]};
    assign diff  = trial - {1'b0, dsr_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
            cnt_next  = CNT_INIT;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // A clear top bit of the difference means the divisor fits.
            if (!diff[DIV_WIDTH])
            begin
                rem_next = diff[DIV_WIDTH-1:0];
                quo_next = {quo_reg[WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DIV_WIDTH-1:0];
                quo_next = {quo_reg[WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// File: rtl/sum_of_two_squares_counter.sv
// Each trial division passes through ST_START and ST_WAIT; ST_FINISH waits while the last result is held.
// The trial divisions run on one bit-serial divider; their count is the number of candidate
// divisors up to the square root of the remaining cofactor plus one per prime factor found.
// A 32-bit prime takes roughly 32768 divisions.
// One word is processed at a time; the next can be accepted in the cycle in which the result first shows.
// rst_n clears the sequencer and the output valid asynchronously; no clearing pass is needed.
module sum_of_two_squares_counter #(
    parameter int NUMBER_BITS = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [ssc_pkg::INPUT_W-1:0]        number,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [ssc_pkg::COUNT_W-1:0]        pair_count
);

    localparam int W  = NUMBER_BITS;
    localparam int DW = (NUMBER_BITS + 1) / 2 + 2;

    ssc_pkg::ssc_state_t state_reg, state_next;

    logic [W-1:0]                     rest_reg, rest_next;
    logic [DW-1:0]                    d_reg, d_next;
    logic [ssc_pkg::EXP_W-1:0]        e_reg, e_next;
    logic [ssc_pkg::PROD_W-1:0]       prod_reg, prod_next;
    logic                             forb_reg, forb_next;
    logic                             two_odd_reg, two_odd_next;
    logic                             other_odd_reg, other_odd_next;
    logic                             zero_reg, zero_next;
    logic                             out_valid_reg, out_valid_next;
    logic [ssc_pkg::COUNT_W-1:0]      pair_count_reg, pair_count_next;

    logic [W-1:0]  number_w;
    logic          div_start;
    logic          div_done;
    logic [W-1:0]  div_quo;
    logic [DW-1:0] div_rem;
    logic [DW-1:0] d_step;
    logic          in_take;
    logic          axis;
    logic          diag;

    generate
        if (W <= ssc_pkg::INPUT_W)
        begin : g_trunc
            assign number_w = number[W-1:0];
        end
        else
        begin : g_ext
            assign number_w = {{(W - ssc_pkg::INPUT_W){1'b0}}, number};
        end
    endgenerate

    ssc_div #(
        .WIDTH     (W),
        .DIV_WIDTH (DW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (rest_reg),
        .divisor   (d_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign in_take = in_valid && !in_stall;
    assign d_step  = (d_reg == DW'(2)) ? DW'(3) : d_reg + DW'(2);

    // n is a square when every exponent is even; n/2 is a square when only the power of two
    // has an odd exponent. Zero counts as both.
    assign axis = zero_reg || (!two_odd_reg && !other_odd_reg);
    assign diag = zero_reg || (two_odd_reg && !other_odd_reg);

    always_comb
    begin
        state_next      = state_reg;
        rest_next       = rest_reg;
        d_next          = d_reg;
        e_next          = e_reg;
        prod_next       = prod_reg;
        forb_next       = forb_reg;
        two_odd_next    = two_odd_reg;
        other_odd_next  = other_odd_reg;
        zero_next       = zero_reg;
        out_valid_next  = out_valid_reg && out_stall;
        pair_count_next = pair_count_reg;
        div_start       = 1'b0;
        in_stall        = (state_reg != ssc_pkg::ST_IDLE);

        unique case (state_reg)
            ssc_pkg::ST_IDLE:
            begin
                if (in_take)
                begin
                    rest_next      = number_w;
                    d_next         = DW'(2);
                    e_next         = '0;
                    prod_next      = ssc_pkg::PROD_W'(1);
                    forb_next      = 1'b0;
                    two_odd_next   = 1'b0;
                    other_odd_next = 1'b0;
                    zero_next      = (number_w == '0);
                    state_next     = ssc_pkg::ST_START;
                end
            end
            ssc_pkg::ST_START:
            begin
                div_start  = 1'b1;
                state_next = ssc_pkg::ST_WAIT;
            end
            ssc_pkg::ST_WAIT:
            begin
                if (div_done)
                begin
                    state_next = ssc_pkg::ST_START;
                    if (e_reg != '0)
                    begin
                        if (div_rem == '0)
                        begin
                            rest_next = div_quo;
                            e_next    = e_reg + ssc_pkg::EXP_W'(1);
                        end
                        else
                        begin
                            // The run of this divisor has ended; fold its exponent in.
                            if (d_reg == DW'(2))
                                two_odd_next = e_reg[0];
                            else if (e_reg[0])
                                other_odd_next = 1'b1;
                            if (d_reg[1:0] == 2'b11 && e_reg[0])
                                forb_next = 1'b1;
                            if (d_reg[1:0] == 2'b01)
                                prod_next = ssc_pkg::sat_mul(prod_reg,
                                    {1'b0, e_reg} + (ssc_pkg::EXP_W+1)'(1));
                            e_next = '0;
                            d_next = d_step;
                        end
                    end
                    else if (div_quo < {{(W - DW){1'b0}}, d_reg})
                    begin
                        // The divisor has passed the square root of the cofactor.
                        state_next = ssc_pkg::ST_TAIL;
                    end
                    else if (div_rem == '0)
                    begin
                        rest_next = div_quo;
                        e_next    = ssc_pkg::EXP_W'(1);
                    end
                    else
                    begin
                        d_next = d_step;
                    end
                end
            end
            ssc_pkg::ST_TAIL:
            begin
                // A cofactor above one is a prime with exponent one.
                if (rest_reg > W'(1))
                begin
                    if (rest_reg == W'(2))
                        two_odd_next = !two_odd_reg;
                    else
                        other_odd_next = 1'b1;
                    if (rest_reg[1:0] == 2'b11)
                        forb_next = 1'b1;
                    if (rest_reg[1:0] == 2'b01)
                        prod_next = ssc_pkg::sat_mul(prod_reg, (ssc_pkg::EXP_W+1)'(2));
                end
                state_next = ssc_pkg::ST_FINISH;
            end
            ssc_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    pair_count_next = ssc_pkg::pair_calc(prod_reg, forb_reg, axis, diag);
                    out_valid_next  = 1'b1;
                    state_next      = ssc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ssc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ssc_pkg::ST_IDLE;
            rest_reg      <= '0;
            d_reg         <= DW'(2);
            e_reg         <= '0;
            prod_reg      <= ssc_pkg::PROD_W'(1);
            forb_reg      <= 1'b0;
            two_odd_reg   <= 1'b0;
            other_odd_reg <= 1'b0;
            zero_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rest_reg      <= rest_next;
            d_reg         <= d_next;
            e_reg         <= e_next;
            prod_reg      <= prod_next;
            forb_reg      <= forb_next;
            two_odd_reg   <= two_odd_next;
            other_odd_reg <= other_odd_next;
            zero_reg      <= zero_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pair_count_reg <= pair_count_next;
    end

    assign out_valid  = out_valid_reg;
    assign pair_count = pair_count_reg;

`ifndef SYNTH
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> (state_reg == ssc_pkg::ST_START))
        else $error("accepted word did not start a trial division");

    a_divisor_form: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ssc_pkg::ST_WAIT) |-> (d_reg == DW'(2) || d_reg[0]))
        else $error("trial divisor is neither two nor odd");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ssc_pkg::ST_FINISH))
        else $error("result word appeared outside the finish step");
`endif

endmodule

// File: dv/sum_of_two_squares_counter_tb.sv
// Self-checking testbench for the two-square pair counter.
module sum_of_two_squares_counter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES  = 40000;
    localparam int DRAIN_CYCLES = 100;
    // Watchdog limit on the simulated run time, in nanoseconds.
    localparam longint LIMIT_NS = 40_000_000;

    typedef struct packed {
        logic [ssc_pkg::INPUT_W-1:0] number;
        logic [ssc_pkg::COUNT_W-1:0] count;
    } pair_expect_t;

    logic                        clk       = 1'b0;
    logic                        rst_n     = 1'b0;
    logic                        in_valid  = 1'b0;
    logic                        in_stall;
    logic [ssc_pkg::INPUT_W-1:0] number    = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic [ssc_pkg::COUNT_W-1:0] pair_count;

    pair_expect_t expected_pairs[$];
    pair_expect_t oldest;
    int           mismatches      = 0;
    int           numbers_sent    = 0;
    int           results_checked = 0;
    int           nonzero_results = 0;
    bit           sender_idles    = 1'b1;
    bit           receiver_idles  = 1'b1;
    logic         hold_active     = 1'b0;
    event         hold_trigger;

    sum_of_two_squares_counter dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .number     (number),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pair_count (pair_count)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Exact test for a square of a value below 2^32.
    function automatic bit is_square(input longint unsigned v);
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        lo = 0;
        hi = 65536;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) >> 1;
            if (mid * mid <= v)
                lo = mid;
            else
                hi = mid - 1;
        end
        return lo * lo == v;
    endfunction

    // Factor by trial division, then turn r2 into unordered positive pairs.
    function automatic logic [ssc_pkg::COUNT_W-1:0] count_pairs(
        input logic [ssc_pkg::INPUT_W-1:0] value);
        longint unsigned n;
        longint unsigned rest;
        longint unsigned d;
        longint unsigned prod;
        longint unsigned e;
        longint unsigned total;
        longint unsigned axis;
        longint unsigned pairs;
        bit              blocked;
        n       = value;
        rest    = n;
        d       = 2;
        prod    = 1;
        blocked = 1'b0;
        while (d <= rest / d)
        begin
            if (rest % d == 0)
            begin
                e = 0;
                while (rest % d == 0)
                begin
                    rest = rest / d;
                    e++;
                end
                if (d % 4 == 3 && e % 2 == 1)
                    blocked = 1'b1;
                if (d % 4 == 1)
                    prod = prod * (e + 1);
            end
            d = (d == 2) ? 3 : d + 2;
        end
        if (rest > 1)
        begin
            if (rest % 4 == 3)
                blocked = 1'b1;
            if (rest % 4 == 1)
                prod = prod * 2;
        end
        total = blocked ? 0 : 4 * prod;
        // Twice a square adds the diagonal pair; a square loses its axis solutions.
        if (n % 2 == 0 && is_square(n >> 1))
            total = total + 4;
        axis  = is_square(n) ? 4 : 0;
        pairs = (total < axis) ? 0 : (total - axis) / 8;
        if (pairs > ssc_pkg::COUNT_MAX)
            pairs = ssc_pkg::COUNT_MAX;
        return pairs[ssc_pkg::COUNT_W-1:0];
    endfunction

    function automatic int unsigned pick_prime(input bit one_mod_four);
        if (one_mod_four)
        begin
            case ($urandom_range(0, 7))
                0: return 5;
                1: return 13;
                2: return 17;
                3: return 29;
                4: return 37;
                5: return 41;
                6: return 53;
                default: return 97;
            endcase
        end
        case ($urandom_range(0, 7))
            0: return 3;
            1: return 7;
            2: return 11;
            3: return 19;
            4: return 23;
            5: return 31;
            6: return 43;
            default: return 79;
        endcase
    endfunction

    // Without break_form, numbers with a representation: squares, twice squares, or products
    // of 2, primes that are 1 mod 4, squared primes that are 3 mod 4 and small squares. All
    // factors stay small so that trial division ends quickly.
    function automatic logic [ssc_pkg::INPUT_W-1:0] build_number(input bit break_form);
        longint unsigned v;
        longint unsigned f;
        int              k;
        v = 1;
        case ($urandom_range(0, 5))
            0:
            begin
                k = $urandom_range(1, 300);
                v = k * k;
            end
            1:
            begin
                k = $urandom_range(1, 300);
                v = 2 * k * k;
            end
            default:
            begin
                repeat ($urandom_range(1, 8))
                begin
                    case ($urandom_range(0, 4))
                        0: f = 2;
                        1, 2: f = pick_prime(1'b1);
                        3:
                        begin
                            f = pick_prime(1'b0);
                            f = f * f;
                        end
                        default:
                        begin
                            k = $urandom_range(2, 12);
                            f = k * k;
                        end
                    endcase
                    if (v * f <= 64'hFFFF_FFFF)
                        v = v * f;
                end
            end
        endcase
        // A lone 3 mod 4 prime or a stray cofactor usually spoils the representation.
        if (break_form)
        begin
            if ($urandom_range(0, 1) != 0)
                f = pick_prime(1'b0);
            else
                f = $urandom_range(2, 600);
            if (v * f <= 64'hFFFF_FFFF)
                v = v * f;
        end
        if ($urandom_range(0, 3) == 0)
        begin
            while (v <= 64'h7FFF_FFFF)
                v = v << 1;
        end
        return v[ssc_pkg::INPUT_W-1:0];
    endfunction

    task automatic send_number(input logic [ssc_pkg::INPUT_W-1:0] value);
        pair_expect_t entry;
        if (sender_idles && $urandom_range(0, 99) < 35)
        begin
            in_valid <= 1'b0;
            number   <= $urandom;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid <= 1'b1;
        number   <= value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        entry.number   = value;
        entry.count    = count_pairs(value);
        expected_pairs = {expected_pairs, entry};
        numbers_sent++;
    endtask

    task automatic report_mismatch(input string what,
                                   input logic [ssc_pkg::INPUT_W-1:0] value,
                                   input logic [ssc_pkg::COUNT_W-1:0] got,
                                   input logic [ssc_pkg::COUNT_W-1:0] want);
        $display("ERROR at %0t: %s, number %0d: got %0d, expected %0d",
                 $realtime, what, value, got, want);
        mismatches++;
    endtask

    task automatic test_directed();
        send_number(32'd0);            // zero
        send_number(32'd1);            // one: zero is not a positive square
        send_number(32'd2);            // 1 + 1, diagonal only
        send_number(32'd3);            // lone 3 mod 4 prime
        send_number(32'd4);            // square with axis solution only
        send_number(32'd5);
        send_number(32'd8);
        send_number(32'd9);            // squared 3 mod 4 prime, axis only
        send_number(32'd25);
        send_number(32'd45);
        send_number(32'd50);           // both a general and a diagonal pair
        send_number(32'd135);          // odd power of 3
        send_number(32'd325);
        send_number(32'd1105);
        send_number(32'h4000_0000);
        send_number(32'h8000_0000);
        send_number(32'hFFFF_FFFF);
        send_number(32'hFFFF_0000);
        send_number(32'h5555_5555);
        send_number(32'hAAAA_AAAA);
        send_number(32'd2576450045);   // seven distinct 1 mod 4 primes, large count
    endtask

    task automatic test_representable(input int count);
        repeat (count)
            send_number(build_number(1'b0));
    endtask

    task automatic test_no_idling(input int count);
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        repeat (count)
            send_number(build_number($urandom_range(0, 3) == 0));
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
    endtask

    task automatic test_noise(input int count);
        repeat (count)
        begin
            if ($urandom_range(0, 1) != 0)
                send_number($urandom_range(0, 18'h3FFFF));
            else
                send_number(build_number(1'b1));
        end
    endtask

    // The output is held off while words keep coming, so the block fills and stalls.
    task automatic test_backpressure(input int count);
        -> hold_trigger;
        repeat (count)
            send_number(build_number(1'b0));
    endtask

    always
    begin
        @(hold_trigger);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (hold_active)
            out_stall <= 1'b1;
        else if (receiver_idles)
            out_stall <= ($urandom_range(0, 99) < 35);
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_pairs.size() == 0)
            begin
                report_mismatch("result with nothing pending", '0, pair_count, '0);
            end
            else
            begin
                oldest = expected_pairs.pop_front();
                if (pair_count !== oldest.count)
                    report_mismatch("pair_count", oldest.number, pair_count, oldest.count);
                if (oldest.count != 0)
                    nonzero_results++;
                results_checked++;
            end
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_representable(55);
        test_no_idling(12);
        test_noise(15);
        test_backpressure(6);
        in_valid <= 1'b0;
        while (expected_pairs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Run covered %0d numbers: corners, representable, unthrottled, noise, held output.",
                 numbers_sent);
        $display("%0d results compared, %0d of them with at least one pair.",
                 results_checked, nonzero_results);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #(LIMIT_NS);
        $display("Timed out with %0d results still pending.", expected_pairs.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
